/* rtl/sfc_pkg.sv */
// sfc_pkg: shared constants, plane codes and the plane-flag struct for the
// sphere/frustum cull pipeline. No dependencies.
`timescale 1ns / 1ps

package sfc_pkg;

  localparam int VAL_W      = 32;  // matrix entries and local center components
  localparam int RAD_W      = 31;  // sphere radius
  localparam int N_W        = 12;  // plane normal component
  localparam int OFF_W      = 28;  // plane offset
  localparam int PLANE_W    = 64;  // packed plane register
  localparam int NUM_PLANES = 6;
  localparam int CFG_IDX_W  = 3;

  // commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  // plane / register indices
  localparam int P_FRONT  = 0;
  localparam int P_BACK   = 1;
  localparam int P_LEFT   = 2;
  localparam int P_RIGHT  = 3;
  localparam int P_TOP    = 4;
  localparam int P_BOTTOM = 5;

  typedef logic [NUM_PLANES-1:0] plane_mask_t;

  typedef struct packed {
    plane_mask_t outside;  // distance above radius
    plane_mask_t below;    // distance below minus radius
  } sfc_flags_t;

  // planes that border a given plane, one bit per plane index
  function automatic plane_mask_t nbr_mask(input int unsigned k);
    plane_mask_t m;
    m = '0;
    unique case (k)
      P_FRONT, P_BACK: begin
        m[P_TOP] = 1'b1; m[P_BOTTOM] = 1'b1; m[P_LEFT] = 1'b1; m[P_RIGHT] = 1'b1;
      end
      P_LEFT, P_RIGHT: begin
        m[P_TOP] = 1'b1; m[P_BOTTOM] = 1'b1; m[P_FRONT] = 1'b1; m[P_BACK] = 1'b1;
      end
      P_TOP, P_BOTTOM: begin
        m[P_LEFT] = 1'b1; m[P_RIGHT] = 1'b1; m[P_FRONT] = 1'b1; m[P_BACK] = 1'b1;
      end
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

/* rtl/sphere_frustum_cull.sv */
// sphere_frustum_cull: top level; chains transform, distance and the final
// keep/cull decision register. Uses sfc_pkg, sfc_xform, sfc_dist.
`timescale 1ns / 1ps

// Bounding-sphere frustum culler. A beat with command LOAD writes one row of
// the 4x3 world matrix and yields no result; a TEST beat transforms the
// sphere center, measures it against the six plane registers and returns one
// result beat (culled, fully_inside). The pipeline is six register stages
// deep (input, matrix products, transform sum/saturate, plane products,
// distances and compares, decision); the input stage loads on the edge that
// takes the beat, and the decision register drives the result outputs. One
// beat is taken every cycle, limited only by the output stall. Each stage
// holds its item while the next one is full, so bubbles close up under back
// pressure. Matrix rows read before being loaded give undefined results.
// Plane registers may be written only when no test is in flight.
module sphere_frustum_cull #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfc_pkg::PLANE_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             command,
  input  logic [1:0]                       world_row,
  input  logic signed [sfc_pkg::VAL_W-1:0] first_value,
  input  logic signed [sfc_pkg::VAL_W-1:0] second_value,
  input  logic signed [sfc_pkg::VAL_W-1:0] third_value,
  input  logic [sfc_pkg::RAD_W-1:0]        sphere_radius,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             culled,
  output logic                             fully_inside
);
  import sfc_pkg::*;

  logic                          x_ready;
  logic                          x_valid, d_ready;
  logic signed [COORD_WIDTH-1:0] x_center [3];
  logic [RAD_W-1:0]              x_radius;
  logic                          e_valid, e_ready;
  sfc_flags_t                    e_flags;

  plane_mask_t                   near;
  logic                          all_inside, kept;

  assign in_stall = !x_ready;

  sfc_xform #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_xform (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (x_ready),
    .command       (command),
    .world_row     (world_row),
    .first_value   (first_value),
    .second_value  (second_value),
    .third_value   (third_value),
    .sphere_radius (sphere_radius),
    .out_valid     (x_valid),
    .out_ready     (d_ready),
    .center        (x_center),
    .radius        (x_radius)
  );

  sfc_dist #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (x_valid),
    .in_ready  (d_ready),
    .center    (x_center),
    .radius    (x_radius),
    .out_valid (e_valid),
    .out_ready (e_ready),
    .flags     (e_flags)
  );

  // straddling a plane keeps the sphere unless a bordering plane has it out
  always_comb begin
    near       = ~e_flags.outside & ~e_flags.below;
    all_inside = &e_flags.below;
    kept       = 1'b0;
    for (int k = 0; k < NUM_PLANES; k++) begin
      if (near[k] && !(|(e_flags.outside & nbr_mask(k)))) begin
        kept = 1'b1;
      end
    end
  end

  assign e_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (e_ready) begin
      out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready) begin
      fully_inside <= all_inside;
      culled       <= !(all_inside || kept);
    end
  end

  a_inside_not_culled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fully_inside) |-> !culled)
    else $error("fully inside sphere reported as culled");

  a_result_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(e_valid))
    else $error("result beat without an item in the compare stage");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && e_valid && x_valid))
    else $error("input stalled while the pipeline has room");

endmodule

/* rtl/sfc_xform.sv */
// sfc_xform: world matrix store and the three-stage center transform
// (input register, matrix products, floor/sum/saturate). Uses sfc_pkg.
`timescale 1ns / 1ps

module sfc_xform #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic [1:0]                          world_row,
  input  logic signed [sfc_pkg::VAL_W-1:0]    first_value,
  input  logic signed [sfc_pkg::VAL_W-1:0]    second_value,
  input  logic signed [sfc_pkg::VAL_W-1:0]    third_value,
  input  logic [sfc_pkg::RAD_W-1:0]           sphere_radius,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COORD_WIDTH-1:0]       center [3],
  output logic [sfc_pkg::RAD_W-1:0]           radius
);
  import sfc_pkg::*;

  localparam int PROD_W = 2 * VAL_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    (SUM_W'(1) <<< (COORD_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic signed [VAL_W-1:0]  mat [12];
  logic signed [VAL_W-1:0]  vin [3];
  logic                     accept;

  // stage A: registered test item
  logic                     va;
  logic signed [VAL_W-1:0]  pa [3];
  logic [RAD_W-1:0]         ra;
  // stage B: products and captured translation
  logic                     vb;
  logic signed [PROD_W-1:0] prod [9];
  logic signed [VAL_W-1:0]  trans [3];
  logic [RAD_W-1:0]         rb;

  logic                     rdy_b, rdy_c;
  logic signed [SUM_W-1:0]  sum [3];
  logic signed [COORD_WIDTH-1:0] sat [3];

  assign vin[0] = first_value;
  assign vin[1] = second_value;
  assign vin[2] = third_value;

  assign rdy_c    = !out_valid || out_ready;
  assign rdy_b    = !vb || rdy_c;
  assign in_ready = !va || rdy_b;
  assign accept   = in_valid && in_ready;

  // row load; a test in stage A reads the matrix on the same edge it leaves,
  // so a load right behind it cannot disturb it
  always_ff @(posedge clk) begin
    if (accept && command == CMD_LOAD) begin
      for (int r = 0; r < 4; r++) begin
        if (world_row == 2'(r)) begin
          for (int c = 0; c < 3; c++) begin
            mat[r*3+c] <= vin[c];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (in_ready) begin
      va <= in_valid && command == CMD_TEST;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      pa <= vin;
      ra <= sphere_radius;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rdy_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i*3+j] <= pa[i] * mat[i*3+j];
        end
        trans[i] <= mat[9+i];
      end
      rb <= ra;
    end
  end

  // arithmetic shift rounds toward minus infinity
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum[j] = SUM_W'(trans[j]) + SUM_W'(prod[j] >>> FRAC_BITS)
             + SUM_W'(prod[3+j] >>> FRAC_BITS) + SUM_W'(prod[6+j] >>> FRAC_BITS);
      if (sum[j] > SAT_HI) begin
        sat[j] = SAT_HI[COORD_WIDTH-1:0];
      end else if (sum[j] < SAT_LO) begin
        sat[j] = SAT_LO[COORD_WIDTH-1:0];
      end else begin
        sat[j] = sum[j][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_c) begin
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      center <= sat;
      radius <= rb;
    end
  end

endmodule

/* rtl/sfc_dist.sv */
// sfc_dist: plane registers and the two-stage signed distance unit
// (normal products, then sum and radius compares). Uses sfc_pkg.
`timescale 1ns / 1ps

module sfc_dist #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [sfc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sfc_pkg::PLANE_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_WIDTH-1:0]        center [3],
  input  logic [sfc_pkg::RAD_W-1:0]            radius,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output sfc_pkg::sfc_flags_t                  flags
);
  import sfc_pkg::*;

  localparam int PW = COORD_WIDTH + N_W;
  localparam int DW = (COORD_WIDTH + 14 > 32 + FRAC_BITS) ? COORD_WIDTH + 14 : 32 + FRAC_BITS;

  logic [PLANE_W-1:0]       planes [NUM_PLANES];
  logic signed [N_W-1:0]    nrm [NUM_PLANES][3];
  logic signed [OFF_W-1:0]  off [NUM_PLANES];

  logic                     vd;
  logic signed [PW-1:0]     pn [NUM_PLANES*3];
  logic [RAD_W-1:0]         rd;

  logic                     rdy_e;
  logic signed [DW-1:0]     rw;
  logic signed [DW-1:0]     d [NUM_PLANES];
  sfc_flags_t               flags_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_PLANES; k++) begin
        planes[k] <= '0;
      end
    end else if (cfg_write) begin
      for (int k = 0; k < NUM_PLANES; k++) begin
        if (cfg_index == CFG_IDX_W'(k)) begin
          planes[k] <= cfg_data;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_PLANES; k++) begin
      for (int i = 0; i < 3; i++) begin
        nrm[k][i] = $signed(planes[k][PLANE_W-1-N_W*i -: N_W]);
      end
      off[k] = $signed(planes[k][OFF_W-1:0]);
    end
  end

  assign rdy_e    = !out_valid || out_ready;
  assign in_ready = !vd || rdy_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (in_ready) begin
      vd <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      for (int k = 0; k < NUM_PLANES; k++) begin
        for (int i = 0; i < 3; i++) begin
          pn[k*3+i] <= nrm[k][i] * center[i];
        end
      end
      rd <= radius;
    end
  end

  // radius and offset brought to the products' 2x fraction scale
  assign rw = $signed(DW'(rd)) <<< FRAC_BITS;

  always_comb begin
    for (int k = 0; k < NUM_PLANES; k++) begin
      d[k] = DW'(pn[k*3]) + DW'(pn[k*3+1]) + DW'(pn[k*3+2])
           + (DW'(off[k]) <<< FRAC_BITS);
      flags_next.outside[k] = d[k] > rw;
      flags_next.below[k]   = d[k] < -rw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_e) begin
      out_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e) begin
      flags <= flags_next;
    end
  end

endmodule
